[hdl/vnsd_pkg.sv]
// shared types and constants for the video no-signal detector
package vnsd_pkg;

   localparam int PixW   = 8;
   localparam int PosW   = 10;
   localparam int WinW   = 11;
   localparam int CountW = 16;
   localparam int ColorW = 24;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 24;

   localparam logic [CsrIdxW-1:0] CSR_THRESHOLD_COLOR  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_DARK_FRAME_LIMIT = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DETECT_ENABLE    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_X_START   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_X_END     = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_Y_START   = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_Y_END     = 3'd6;

   localparam logic [ColorW-1:0] THRESHOLD_RESET = 24'd0;
   localparam logic [CountW-1:0] LIMIT_RESET     = 16'd40;
   localparam logic [WinW-1:0]   WIN_START_RESET = 11'd256;
   localparam logic [WinW-1:0]   WIN_END_RESET   = 11'd768;
   localparam logic [CountW-1:0] COUNT_MAX       = 16'hFFFF;

   typedef struct packed {
      logic [PixW-1:0] pixel_red;
      logic [PixW-1:0] pixel_green;
      logic [PixW-1:0] pixel_blue;
      logic [PosW-1:0] column;
      logic [PosW-1:0] row;
      logic            frame_end;
   } pix_type;

   typedef struct packed {
      logic [ColorW-1:0] threshold_color;
      logic [CountW-1:0] dark_frame_limit;
      logic              detect_enable;
      logic [WinW-1:0]   window_x_start;
      logic [WinW-1:0]   window_x_end;
      logic [WinW-1:0]   window_y_start;
      logic [WinW-1:0]   window_y_end;
   } cfg_type;

   typedef struct packed {
      logic forward_frame;
      logic signal_lost;
      logic signal_found;
      logic frame_dark;
      logic signal_present;
   } res_type;

endpackage

[hdl/vnsd_ifs.sv]
// request and response channel interfaces
interface vnsd_req_if;
   logic                       valid;
   logic                       ready;
   logic [vnsd_pkg::PixW-1:0]  pixel_red;
   logic [vnsd_pkg::PixW-1:0]  pixel_green;
   logic [vnsd_pkg::PixW-1:0]  pixel_blue;
   logic [vnsd_pkg::PosW-1:0]  column;
   logic [vnsd_pkg::PosW-1:0]  row;
   logic                       frame_end;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, column, row,
                   frame_end, input ready);
   modport sink   (input valid, pixel_red, pixel_green, pixel_blue, column, row,
                   frame_end, output ready);
endinterface

interface vnsd_rsp_if;
   logic valid;
   logic ready;
   logic forward_frame;
   logic signal_lost;
   logic signal_found;
   logic frame_dark;
   logic signal_present;

   modport source (output valid, forward_frame, signal_lost, signal_found, frame_dark,
                   signal_present, input ready);
   modport sink   (input valid, forward_frame, signal_lost, signal_found, frame_dark,
                   signal_present, output ready);
endinterface

[hdl/video_no_signal_detector.sv]
// top level of the video no-signal detector
//
//   channel   dir  handshake          payload
//   req_bus   in   valid / ready      pixel_red, pixel_green, pixel_blue, column, row, frame_end
//   rsp_bus   out  valid / ready      forward_frame, signal_lost, signal_found, frame_dark,
//                                     signal_present
//   csr_*     in   csr_we (no ready)  csr_index, csr_wdata
//
// one request per cycle sustained while no frame end is stalled; a request is held in the
// input register, and its result (frame end only) is then registered in the response register
// reset is synchronous, active high; no clearing pass, the block takes requests at once
// only a frame-end request waits in the input register while the response register is
// full and not taken; other pixels keep flowing
module video_no_signal_detector #(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   vnsd_req_if.sink                          req_bus,
   vnsd_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [vnsd_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [vnsd_pkg::CsrDataW-1:0]     csr_wdata
);
   // configuration registers
   vnsd_pkg::cfg_type cfg_ff, cfg_in;

   // input register
   logic              pix_valid_ff, pix_valid_in;
   vnsd_pkg::pix_type pix_ff, pix_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   vnsd_pkg::res_type rsp_ff, rsp_in;

   logic              req_take;
   logic              pix_step;
   logic              rsp_load;
   logic              bright;
   vnsd_pkg::res_type res;

   // csr writes, index beyond the list is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            vnsd_pkg::CSR_THRESHOLD_COLOR:  cfg_in.threshold_color  = csr_wdata;
            vnsd_pkg::CSR_DARK_FRAME_LIMIT: cfg_in.dark_frame_limit = csr_wdata[15:0];
            vnsd_pkg::CSR_DETECT_ENABLE:    cfg_in.detect_enable    = csr_wdata[0];
            vnsd_pkg::CSR_WINDOW_X_START:   cfg_in.window_x_start   = csr_wdata[10:0];
            vnsd_pkg::CSR_WINDOW_X_END:     cfg_in.window_x_end     = csr_wdata[10:0];
            vnsd_pkg::CSR_WINDOW_Y_START:   cfg_in.window_y_start   = csr_wdata[10:0];
            vnsd_pkg::CSR_WINDOW_Y_END:     cfg_in.window_y_end     = csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_color  <= vnsd_pkg::THRESHOLD_RESET;
         cfg_ff.dark_frame_limit <= vnsd_pkg::LIMIT_RESET;
         cfg_ff.detect_enable    <= 1'b1;
         cfg_ff.window_x_start   <= vnsd_pkg::WIN_START_RESET;
         cfg_ff.window_x_end     <= vnsd_pkg::WIN_END_RESET;
         cfg_ff.window_y_start   <= vnsd_pkg::WIN_START_RESET;
         cfg_ff.window_y_end     <= vnsd_pkg::WIN_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the held pixel moves on unless it is a frame end blocked by a full response
   assign pix_step = pix_valid_ff && (!pix_ff.frame_end || !rsp_valid_ff || rsp_bus.ready);
   assign rsp_load = pix_step && pix_ff.frame_end;
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !pix_valid_ff || pix_step;

   always_comb begin
      pix_in.pixel_red   = req_bus.pixel_red;
      pix_in.pixel_green = req_bus.pixel_green;
      pix_in.pixel_blue  = req_bus.pixel_blue;
      pix_in.column      = req_bus.column;
      pix_in.row         = req_bus.row;
      pix_in.frame_end   = req_bus.frame_end;
      pix_valid_in       = req_take ? 1'b1 : (pix_step ? 1'b0 : pix_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_ff <= pix_in;
      end
   end

   vnsd_win_check #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_win_check (
      .pix    (pix_ff),
      .cfg    (cfg_ff),
      .bright (bright)
   );

   vnsd_frame_eval u_frame_eval (
      .clock     (clock),
      .reset     (reset),
      .step      (pix_step),
      .frame_end (pix_ff.frame_end),
      .bright    (bright),
      .cfg       (cfg_ff),
      .res       (res)
   );

   // response register, refilled in the same cycle it is taken
   assign rsp_in       = res;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.forward_frame  = rsp_ff.forward_frame;
   assign rsp_bus.signal_lost    = rsp_ff.signal_lost;
   assign rsp_bus.signal_found   = rsp_ff.signal_found;
   assign rsp_bus.frame_dark     = rsp_ff.frame_dark;
   assign rsp_bus.signal_present = rsp_ff.signal_present;
endmodule

[hdl/vnsd_win_check.sv]
// per-pixel window test and threshold compare
module vnsd_win_check #(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024
) (
   input  vnsd_pkg::pix_type pix,
   input  vnsd_pkg::cfg_type cfg,
   output logic              bright
);
   localparam int DimW = 13;

   logic [DimW-1:0]             col_ext;
   logic [DimW-1:0]             row_ext;
   logic [vnsd_pkg::WinW-1:0]   col_w;
   logic [vnsd_pkg::WinW-1:0]   row_w;
   logic                        in_frame;
   logic                        in_win;
   logic                        over;

   assign col_ext = DimW'(pix.column);
   assign row_ext = DimW'(pix.row);
   assign col_w   = vnsd_pkg::WinW'(pix.column);
   assign row_w   = vnsd_pkg::WinW'(pix.row);

   assign in_frame = (col_ext < DimW'(FRAME_WIDTH)) && (row_ext < DimW'(FRAME_HEIGHT));
   assign in_win   = (col_w >= cfg.window_x_start) && (col_w < cfg.window_x_end) &&
                     (row_w >= cfg.window_y_start) && (row_w < cfg.window_y_end);

   assign over = (pix.pixel_red   > cfg.threshold_color[23:16]) ||
                 (pix.pixel_green > cfg.threshold_color[15:8])  ||
                 (pix.pixel_blue  > cfg.threshold_color[7:0]);

   assign bright = in_frame && in_win && over;
endmodule

[hdl/vnsd_frame_eval.sv]
// dark-frame run tracking and event decision
module vnsd_frame_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              frame_end,
   input  logic              bright,
   input  vnsd_pkg::cfg_type cfg,
   output vnsd_pkg::res_type res
);
   logic                          all_dark_ff, all_dark_in;
   logic [vnsd_pkg::CountW-1:0]   count_ff, count_in;
   logic                          flag_ff, flag_in;
   logic                          dark;
   logic [vnsd_pkg::CountW-1:0]   limit;
   logic [vnsd_pkg::CountW-1:0]   count_new;
   logic                          found;
   logic                          lost;
   logic                          fwd;
   logic                          flag_new;

   assign dark  = all_dark_ff && !bright;
   assign limit = (cfg.dark_frame_limit == '0) ? vnsd_pkg::CountW'(1) : cfg.dark_frame_limit;

   always_comb begin
      count_new = count_ff;
      found     = 1'b0;
      lost      = 1'b0;
      fwd       = 1'b1;
      flag_new  = flag_ff;
      if (cfg.detect_enable) begin
         if (dark) begin
            if (count_ff != vnsd_pkg::COUNT_MAX) begin
               count_new = count_ff + vnsd_pkg::CountW'(1);
            end
         end else begin
            found     = (count_ff >= limit);
            count_new = '0;
         end
         fwd  = (count_new < limit);
         lost = !fwd && (count_new == limit) && (count_ff != limit);
         if (found) begin
            flag_new = 1'b1;
         end else if (lost) begin
            flag_new = 1'b0;
         end
      end
   end

   always_comb begin
      all_dark_in = all_dark_ff;
      count_in    = count_ff;
      flag_in     = flag_ff;
      if (step) begin
         if (frame_end) begin
            all_dark_in = 1'b1;
            count_in    = count_new;
            flag_in     = flag_new;
         end else begin
            all_dark_in = dark;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_dark_ff <= 1'b1;
         count_ff    <= '0;
         flag_ff     <= 1'b0;
      end else begin
         all_dark_ff <= all_dark_in;
         count_ff    <= count_in;
         flag_ff     <= flag_in;
      end
   end

   assign res.forward_frame  = fwd;
   assign res.signal_lost    = lost;
   assign res.signal_found   = found;
   assign res.frame_dark     = dark;
   assign res.signal_present = flag_new;
endmodule
